[sv/hrc_pkg.sv]
// Shared types, constants and checksum helpers for the header randomizer.
`default_nettype none
package hrc_pkg;

    localparam int RAND_W = 31;
    localparam int REM_BITS = 4;
    localparam int REM_STAGES = 8;
    localparam int DIVD_W = REM_BITS * REM_STAGES;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_PORT_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_PORT_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_PORT_LOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_PORT_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_ADDR_BASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DST_ADDR_MASK = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_ADDR_BASE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_ADDR_MASK = 3'd7;

    localparam logic [31:0] MASK_ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [15:0] src_port_low;
        logic [15:0] src_port_high;
        logic [15:0] dst_port_low;
        logic [15:0] dst_port_high;
        logic [31:0] dst_addr_base;
        logic [31:0] dst_addr_mask;
        logic [31:0] src_addr_base;
        logic [31:0] src_addr_mask;
    } cfg_t;

    typedef struct packed {
        logic [15:0]       old_src_port;
        logic [15:0]       old_dst_port;
        logic [31:0]       old_dst_addr;
        logic [31:0]       old_src_addr;
        logic [15:0]       old_ip_sum;
        logic [15:0]       old_tcp_sum;
        logic [RAND_W-1:0] rand_src_port;
        logic [RAND_W-1:0] rand_dst_port;
        logic [RAND_W-1:0] rand_dst_addr;
        logic [RAND_W-1:0] rand_src_addr;
    } item_t;

    typedef struct packed {
        logic [15:0] new_src_port;
        logic [15:0] new_dst_port;
        logic [31:0] new_dst_addr;
        logic [31:0] new_src_addr;
        logic [15:0] old_dst_port;
        logic [31:0] old_dst_addr;
        logic [31:0] old_src_addr;
        logic [15:0] ip_sum;
        logic [15:0] tcp_sum;
        logic        dport_en;
        logic        daddr_en;
        logic        saddr_en;
    } work_t;

    // Add the two 16-bit halves of an address.
    function automatic logic [16:0] word_sum(input logic [31:0] v);
        return 17'(v[31:16]) + 17'(v[15:0]);
    endfunction

    // Incremental checksum update: sum - new + old, folded twice.
    function automatic logic [15:0] fix_sum(input logic [15:0] sum,
                                            input logic [16:0] nw,
                                            input logic [16:0] ow);
        logic signed [18:0] acc;
        logic [17:0]        mag;
        logic [16:0]        f1;
        logic [16:0]        f2;
        acc = $signed({3'b000, sum}) - $signed({2'b00, nw}) + $signed({2'b00, ow});
        mag = acc[18] ? 18'(-acc) : acc[17:0];
        f1 = 17'(mag[17:16]) + 17'(mag[15:0]);
        f2 = f1 + 17'(f1[16]);
        return acc[18] ? ~f2[15:0] : f2[15:0];
    endfunction

endpackage
`default_nettype wire

[sv/header_randomizer_checksum_fixup.sv]
// Top level of the header randomizer with incremental checksum fixup.
// Usage:
//   Configure the eight registers through cfg_valid/cfg_index/cfg_data while
//   no word is in flight; cfg_ready is always high. Index 0..7 follows the
//   register list; each write is registered.
//   Input words (s_valid/s_ready) carry one header's ports, addresses and
//   checksums plus four random words. Result words (m_valid/m_ready) carry
//   the rewritten fields and both updated checksums, one per input word,
//   in order.
//   The word lands in the input register at the accepting edge, then eight
//   remainder stages (four restoring bits each for the port choice) and four
//   checksum stages follow before the result reaches m_valid.
//   Throughput is one word per cycle while the receiver does not stall.
//   When the receiver holds m_ready low with a result waiting, the whole
//   pipeline freezes and s_ready drops; nothing is lost or repeated.
//   Reset empties the pipeline and restores the register defaults (both
//   address masks all ones, everything else zero).
`default_nettype none
module header_randomizer_checksum_fixup (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hrc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [15:0]                    s_old_src_port,
    input  wire logic [15:0]                    s_old_dst_port,
    input  wire logic [31:0]                    s_old_dst_addr,
    input  wire logic [31:0]                    s_old_src_addr,
    input  wire logic [15:0]                    s_old_ip_sum,
    input  wire logic [15:0]                    s_old_tcp_sum,
    input  wire logic [hrc_pkg::RAND_W-1:0]     s_rand_src_port,
    input  wire logic [hrc_pkg::RAND_W-1:0]     s_rand_dst_port,
    input  wire logic [hrc_pkg::RAND_W-1:0]     s_rand_dst_addr,
    input  wire logic [hrc_pkg::RAND_W-1:0]     s_rand_src_addr,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [15:0]                         m_new_src_port,
    output logic [15:0]                         m_new_dst_port,
    output logic [31:0]                         m_new_dst_addr,
    output logic [31:0]                         m_new_src_addr,
    output logic [15:0]                         m_new_ip_sum,
    output logic [15:0]                         m_new_tcp_sum
);

    localparam int NS = hrc_pkg::REM_STAGES;
    localparam int RB = hrc_pkg::REM_BITS;

    hrc_pkg::cfg_t cfg;
    logic          ce;

    hrc_pkg::item_t item_reg [0:NS];
    logic           vld_reg  [0:NS];
    logic [15:0]    rem_sp   [0:NS];
    logic [15:0]    rem_dp   [0:NS];
    logic [15:0]    div_sp;
    logic [15:0]    div_dp;
    logic           sp_en;
    logic           dp_en;
    logic           sp_span;
    logic           dp_span;

    hrc_pkg::work_t a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic           a_vld_reg, b_vld_reg, c_vld_reg, o_vld_reg;
    logic [15:0]    o_ip_reg, o_ip_next, o_tcp_reg, o_tcp_next;
    logic [15:0]    o_sp_reg, o_dp_reg;
    logic [31:0]    o_da_reg, o_sa_reg;

    hrc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign cfg_ready = 1'b1;

    // Advance everything unless a result waits on a stalled receiver
    assign ce = !o_vld_reg || m_ready;
    assign s_ready = ce;

    assign sp_en = (cfg.src_port_low | cfg.src_port_high) != 16'd0;
    assign dp_en = (cfg.dst_port_low | cfg.dst_port_high) != 16'd0;
    assign sp_span = cfg.src_port_high > cfg.src_port_low;
    assign dp_span = cfg.dst_port_high > cfg.dst_port_low;
    assign div_sp = cfg.src_port_high - cfg.src_port_low;
    assign div_dp = cfg.dst_port_high - cfg.dst_port_low;

    // Capture the input word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= s_valid;
        end
        if (ce) begin
            item_reg[0] <= '{s_old_src_port, s_old_dst_port, s_old_dst_addr,
                             s_old_src_addr, s_old_ip_sum, s_old_tcp_sum,
                             s_rand_src_port, s_rand_dst_port, s_rand_dst_addr,
                             s_rand_src_addr};
        end
    end

    assign rem_sp[0] = 16'd0;
    assign rem_dp[0] = 16'd0;

    // Remainder pipeline for both port choices
    for (genvar k = 1; k <= NS; k++) begin : g_rem
        logic [hrc_pkg::DIVD_W-1:0] dsp;
        logic [hrc_pkg::DIVD_W-1:0] ddp;
        assign dsp = hrc_pkg::DIVD_W'(item_reg[k-1].rand_src_port);
        assign ddp = hrc_pkg::DIVD_W'(item_reg[k-1].rand_dst_port);

        hrc_rem_stage u_sp (
            .aclk   (aclk),
            .ce     (ce),
            .rem_i  (rem_sp[k-1]),
            .bits_i (dsp[hrc_pkg::DIVD_W-1-(k-1)*RB -: RB]),
            .div_i  (div_sp),
            .rem_o  (rem_sp[k])
        );

        hrc_rem_stage u_dp (
            .aclk   (aclk),
            .ce     (ce),
            .rem_i  (rem_dp[k-1]),
            .bits_i (ddp[hrc_pkg::DIVD_W-1-(k-1)*RB -: RB]),
            .div_i  (div_dp),
            .rem_o  (rem_dp[k])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ce) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            if (ce) begin
                item_reg[k] <= item_reg[k-1];
            end
        end
    end

    // Pick new fields and apply the source port update
    always_comb begin
        hrc_pkg::item_t it;
        logic [15:0] sp;
        logic [15:0] dp;
        it = item_reg[NS];
        sp = sp_span ? cfg.src_port_low + rem_sp[NS] : cfg.src_port_low;
        dp = dp_span ? cfg.dst_port_low + rem_dp[NS] : cfg.dst_port_low;
        a_next.new_src_port = sp_en ? sp : it.old_src_port;
        a_next.new_dst_port = dp_en ? dp : it.old_dst_port;
        a_next.new_dst_addr = (cfg.dst_addr_base & cfg.dst_addr_mask)
                            | (~cfg.dst_addr_mask & 32'(it.rand_dst_addr));
        a_next.new_src_addr = (cfg.src_addr_base & cfg.src_addr_mask)
                            | (~cfg.src_addr_mask & 32'(it.rand_src_addr));
        a_next.old_dst_port = it.old_dst_port;
        a_next.old_dst_addr = it.old_dst_addr;
        a_next.old_src_addr = it.old_src_addr;
        a_next.ip_sum = it.old_ip_sum;
        a_next.tcp_sum = sp_en ? hrc_pkg::fix_sum(it.old_tcp_sum, 17'(sp),
                                                  17'(it.old_src_port))
                               : it.old_tcp_sum;
        a_next.dport_en = dp_en;
        a_next.daddr_en = cfg.dst_addr_mask != hrc_pkg::MASK_ALL_ONES;
        a_next.saddr_en = cfg.src_addr_mask != hrc_pkg::MASK_ALL_ONES;
    end

    // Destination port into TCP, destination address into IP
    always_comb begin
        b_next = a_reg;
        if (a_reg.dport_en) begin
            b_next.tcp_sum = hrc_pkg::fix_sum(a_reg.tcp_sum, 17'(a_reg.new_dst_port),
                                              17'(a_reg.old_dst_port));
        end
        if (a_reg.daddr_en) begin
            b_next.ip_sum = hrc_pkg::fix_sum(a_reg.ip_sum,
                                             hrc_pkg::word_sum(a_reg.new_dst_addr),
                                             hrc_pkg::word_sum(a_reg.old_dst_addr));
        end
    end

    // Destination address into TCP, source address into IP
    always_comb begin
        c_next = b_reg;
        if (b_reg.daddr_en) begin
            c_next.tcp_sum = hrc_pkg::fix_sum(b_reg.tcp_sum,
                                              hrc_pkg::word_sum(b_reg.new_dst_addr),
                                              hrc_pkg::word_sum(b_reg.old_dst_addr));
        end
        if (b_reg.saddr_en) begin
            c_next.ip_sum = hrc_pkg::fix_sum(b_reg.ip_sum,
                                             hrc_pkg::word_sum(b_reg.new_src_addr),
                                             hrc_pkg::word_sum(b_reg.old_src_addr));
        end
    end

    // Source address into TCP
    always_comb begin
        o_ip_next = c_reg.ip_sum;
        o_tcp_next = c_reg.saddr_en
                   ? hrc_pkg::fix_sum(c_reg.tcp_sum,
                                      hrc_pkg::word_sum(c_reg.new_src_addr),
                                      hrc_pkg::word_sum(c_reg.old_src_addr))
                   : c_reg.tcp_sum;
    end

    // Advance the checksum stages and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end else if (ce) begin
            a_vld_reg <= vld_reg[NS];
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            o_vld_reg <= c_vld_reg;
        end
        if (ce) begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            o_ip_reg <= o_ip_next;
            o_tcp_reg <= o_tcp_next;
            o_sp_reg <= c_reg.new_src_port;
            o_dp_reg <= c_reg.dport_en ? c_reg.new_dst_port : c_reg.old_dst_port;
            o_da_reg <= c_reg.daddr_en ? c_reg.new_dst_addr : c_reg.old_dst_addr;
            o_sa_reg <= c_reg.saddr_en ? c_reg.new_src_addr : c_reg.old_src_addr;
        end
    end

    assign m_valid = o_vld_reg;
    assign m_new_src_port = o_sp_reg;
    assign m_new_dst_port = o_dp_reg;
    assign m_new_dst_addr = o_da_reg;
    assign m_new_src_addr = o_sa_reg;
    assign m_new_ip_sum = o_ip_reg;
    assign m_new_tcp_sum = o_tcp_reg;

endmodule
`default_nettype wire

[sv/hrc_cfg_regs.sv]
// Configuration register file for the header randomizer.
`default_nettype none
module hrc_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    input  wire logic [hrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hrc_pkg::CFG_DATA_W-1:0] cfg_data,
    output hrc_pkg::cfg_t                       cfg
);

    hrc_pkg::cfg_t cfg_reg;
    hrc_pkg::cfg_t cfg_next;

    // Decode the write word into its register
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                hrc_pkg::REG_SRC_PORT_LOW:  cfg_next.src_port_low  = cfg_data[15:0];
                hrc_pkg::REG_SRC_PORT_HIGH: cfg_next.src_port_high = cfg_data[15:0];
                hrc_pkg::REG_DST_PORT_LOW:  cfg_next.dst_port_low  = cfg_data[15:0];
                hrc_pkg::REG_DST_PORT_HIGH: cfg_next.dst_port_high = cfg_data[15:0];
                hrc_pkg::REG_DST_ADDR_BASE: cfg_next.dst_addr_base = cfg_data;
                hrc_pkg::REG_DST_ADDR_MASK: cfg_next.dst_addr_mask = cfg_data;
                hrc_pkg::REG_SRC_ADDR_BASE: cfg_next.src_addr_base = cfg_data;
                hrc_pkg::REG_SRC_ADDR_MASK: cfg_next.src_addr_mask = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{16'd0, 16'd0, 16'd0, 16'd0,
                         32'd0, hrc_pkg::MASK_ALL_ONES,
                         32'd0, hrc_pkg::MASK_ALL_ONES};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[sv/hrc_rem_stage.sv]
// One stage of the pipelined remainder: REM_BITS restoring steps, registered.
`default_nettype none
module hrc_rem_stage (
    input  wire logic                         aclk,
    input  wire logic                         ce,
    input  wire logic [15:0]                  rem_i,
    input  wire logic [hrc_pkg::REM_BITS-1:0] bits_i,
    input  wire logic [15:0]                  div_i,
    output logic [15:0]                       rem_o
);

    logic [15:0] rem_reg;
    logic [15:0] rem_next;

    // Shift in one dividend bit per step and subtract when it fits
    always_comb begin
        logic [16:0] t;
        rem_next = rem_i;
        for (int i = hrc_pkg::REM_BITS - 1; i >= 0; i--) begin
            t = {rem_next, bits_i[i]};
            if (t >= 17'(div_i)) begin
                t = t - 17'(div_i);
            end
            rem_next = t[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg <= rem_next;
        end
    end

    assign rem_o = rem_reg;

endmodule
`default_nettype wire
